@@ hw/rtl/sdtq_pkg.sv @@
// Shared types, codes and helpers for the sorted deadline timer queue.
package sdtq_pkg;

  localparam int unsigned IDENTS   = 16;
  localparam int unsigned MAX_OUT  = 16;
  localparam int unsigned NEXT_W   = 18;
  localparam logic [31:0] NEXT_MAX = 32'd131071;

  typedef enum logic [1:0] {
    OP_START_ONE = 2'd0,
    OP_START_PER = 2'd1,
    OP_CANCEL    = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_STARTED   = 3'd0,
    K_REFUSED   = 3'd1,
    K_CANCELLED = 3'd2,
    K_ABSENT    = 3'd3,
    K_EXPIRED   = 3'd4,
    K_QUIET     = 3'd5
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_POP   = 5'b00100,
    ST_REINS = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic accept;
    logic pop;
    logic reins;
    logic quiet;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic head_per;
    logic nres_zero;
    logic out_free;
    logic rd_last;
  } stat_t;

  // true when deadline a lies strictly before time b (wrapping)
  function automatic logic is_earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

@@ hw/rtl/sdtq_ctrl.sv @@
// Sequencer for the timer queue: request intake, expiry loop, result emission.
module sdtq_ctrl
  import sdtq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  input  stat_t      stat_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (in_op_i == OP_TICK) ? ST_CHECK : ST_EMIT;
        end
      end
      ST_CHECK: begin
        if (stat_i.due) begin
          state_d = ST_POP;
        end else begin
          cmd_o.quiet = stat_i.nres_zero;
          state_d = ST_EMIT;
        end
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d = stat_i.head_per ? ST_REINS : ST_CHECK;
      end
      ST_REINS: begin
        cmd_o.reins = 1'b1;
        state_d = ST_CHECK;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.rd_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  a_pop_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |=> state_q == ST_REINS || state_q == ST_CHECK)
    else $error("pop not followed by reinsert or check");

  a_reins_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REINS |-> $past(state_q) == ST_POP)
    else $error("reinsert without pop");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

@@ hw/rtl/sdtq_dp.sv @@
// Timer queue datapath: sorted slot cells, clock, identifiers, result buffer.
module sdtq_dp
  import sdtq_pkg::*;
#(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] tag_i,
  input  logic [3:0]  cancel_id_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  out_kind_o,
  output logic [3:0]  out_id_o,
  output logic [15:0] out_tag_o,
  output logic [NEXT_W-1:0] out_next_o,
  output logic        out_last_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned MB = (DELAY_BITS >= 16) ? 16 : DELAY_BITS;
  localparam logic [15:0] DMASK = 16'((32'd1 << MB) - 32'd1);

  logic [31:0]      now_q;
  logic [CW-1:0]    cnt_q;
  logic [31:0]      dl_q  [SLOTS];
  logic [15:0]      per_q [SLOTS];
  logic [15:0]      tag_q [SLOTS];
  logic [3:0]       id_q  [SLOTS];
  logic [IDENTS-1:0] ident_q;
  logic [31:0]      hold_dl_q;
  logic [15:0]      hold_per_q, hold_tag_q;
  logic [3:0]       hold_id_q;
  kind_e            rb_kind_q [MAX_OUT];
  logic [3:0]       rb_id_q   [MAX_OUT];
  logic [15:0]      rb_tag_q  [MAX_OUT];
  logic [4:0]       nres_q;
  logic [3:0]       rd_q;
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [3:0]       out_id_q;
  logic [15:0]      out_tag_q;
  logic [NEXT_W-1:0] out_next_q;
  logic             out_last_q;

  logic [SLOTS-1:0] valid, ge, stop, ins_oh, below, match, first, rem_q;
  logic [31:0]      new_dl;
  logic [15:0]      new_per, new_tag, dm, d_eff;
  logic [3:0]       new_id, free_id;
  logic [IDENTS-1:0] free_oh;
  logic             is_start, is_cancel, is_tick, can_start, hit, do_ins, do_rem;
  logic [31:0]      diff;
  logic [NEXT_W-1:0] next_val;

  assign is_start  = (op_i == OP_START_ONE) || (op_i == OP_START_PER);
  assign is_cancel = (op_i == OP_CANCEL);
  assign is_tick   = (op_i == OP_TICK);

  // lowest free identifier
  assign free_oh = ~ident_q & (ident_q + 16'd1);
  always_comb begin
    free_id = '0;
    for (int k = 0; k < IDENTS; k++) if (free_oh[k]) free_id = 4'(k);
  end
  assign can_start = (ident_q != '1) && (cnt_q < CW'(SLOTS));

  assign dm    = delay_i & DMASK;
  assign d_eff = (op_i == OP_START_PER && dm == 16'd0) ? 16'd1 : dm;

  // candidate for a sorted insert
  always_comb begin
    if (cmd_i.reins) begin
      new_dl  = hold_dl_q + {16'd0, hold_per_q};
      new_per = hold_per_q;
      new_tag = hold_tag_q;
      new_id  = hold_id_q;
    end else begin
      new_dl  = now_q + {16'd0, d_eff};
      new_per = (op_i == OP_START_PER) ? d_eff : 16'd0;
      new_tag = tag_i;
      new_id  = free_id;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      valid[i] = (CW'(i) < cnt_q);
      ge[i]    = valid[i] && !is_earlier(new_dl, dl_q[i]);
      match[i] = cmd_i.pop ? (i == 0) : (valid[i] && id_q[i] == cancel_id_i);
    end
  end

  // insert lands at the first slot that does not stay ahead
  assign stop   = ~ge;
  assign ins_oh = stop & (~stop + SLOTS'(1));
  assign below  = ins_oh - SLOTS'(1);
  // removal shifts every cell at or after the first match
  assign first  = match & (~match + SLOTS'(1));
  assign rem_q  = ~(first - SLOTS'(1));
  assign hit    = |match;

  assign do_ins = (cmd_i.accept && is_start && can_start) || cmd_i.reins;
  assign do_rem = (cmd_i.accept && is_cancel && hit) || (cmd_i.pop && cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (ins_oh[i]) begin
          dl_q[i]  <= new_dl;
          per_q[i] <= new_per;
          tag_q[i] <= new_tag;
          id_q[i]  <= new_id;
        end
      end
      for (int i = 1; i < SLOTS; i++) begin
        if (!ins_oh[i] && !below[i]) begin
          dl_q[i]  <= dl_q[i-1];
          per_q[i] <= per_q[i-1];
          tag_q[i] <= tag_q[i-1];
          id_q[i]  <= id_q[i-1];
        end
      end
    end else if (do_rem) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (rem_q[i]) begin
          dl_q[i]  <= dl_q[i+1];
          per_q[i] <= per_q[i+1];
          tag_q[i] <= tag_q[i+1];
          id_q[i]  <= id_q[i+1];
        end
      end
    end
    if (cmd_i.pop) begin
      hold_dl_q  <= dl_q[0];
      hold_per_q <= per_q[0];
      hold_tag_q <= tag_q[0];
      hold_id_q  <= id_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      cnt_q   <= '0;
      ident_q <= '0;
    end else begin
      if (cmd_i.accept && is_tick) now_q <= now_q + 32'd1;
      if (do_ins && !do_rem) cnt_q <= cnt_q + CW'(1);
      else if (do_rem && !do_ins) cnt_q <= cnt_q - CW'(1);
      if (cmd_i.accept && is_start && can_start) ident_q[free_id] <= 1'b1;
      if (cmd_i.accept && is_cancel && hit) ident_q[cancel_id_i] <= 1'b0;
      if (cmd_i.pop && per_q[0] == 16'd0) ident_q[id_q[0]] <= 1'b0;
    end
  end

  // result buffer, filled while the request runs
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !is_tick) begin
      rb_tag_q[0] <= '0;
      if (is_start) begin
        rb_kind_q[0] <= can_start ? K_STARTED : K_REFUSED;
        rb_id_q[0]   <= can_start ? free_id : 4'd0;
      end else begin
        rb_kind_q[0] <= hit ? K_CANCELLED : K_ABSENT;
        rb_id_q[0]   <= cancel_id_i;
      end
    end else if (cmd_i.pop) begin
      rb_kind_q[nres_q[3:0]] <= K_EXPIRED;
      rb_id_q[nres_q[3:0]]   <= id_q[0];
      rb_tag_q[nres_q[3:0]]  <= tag_q[0];
    end else if (cmd_i.quiet) begin
      rb_kind_q[0] <= K_QUIET;
      rb_id_q[0]   <= '0;
      rb_tag_q[0]  <= '0;
    end
  end

  // time to the head deadline, after the whole request
  assign diff = dl_q[0] - now_q;
  always_comb begin
    if (cnt_q == '0) next_val = '1;
    else if (diff[31]) next_val = '0;
    else if (diff >= NEXT_MAX) next_val = NEXT_MAX[NEXT_W-1:0];
    else next_val = diff[NEXT_W-1:0] + NEXT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nres_q      <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        nres_q <= is_tick ? 5'd0 : 5'd1;
        rd_q   <= '0;
      end else if (cmd_i.pop || cmd_i.quiet) begin
        nres_q <= nres_q + 5'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        rd_q        <= rd_q + 4'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= rb_kind_q[rd_q];
      out_id_q   <= rb_id_q[rd_q];
      out_tag_q  <= rb_tag_q[rd_q];
      out_next_q <= next_val;
      out_last_q <= stat_o.rd_last;
    end
  end

  assign stat_o.due       = (cnt_q != '0) && is_earlier(dl_q[0], now_q) &&
                            (nres_q != 5'(MAX_OUT));
  assign stat_o.head_per  = (per_q[0] != 16'd0);
  assign stat_o.nres_zero = (nres_q == 5'd0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.rd_last   = ({1'b0, rd_q} + 5'd1 == nres_q);

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_tag_o   = out_tag_q;
  assign out_next_o  = out_next_q;
  assign out_last_o  = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("slot count beyond capacity");

  a_ident_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(ident_q) >= int'(cnt_q))
    else $error("queued timer without identifier");

  a_reins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reins |-> cnt_q < CW'(SLOTS))
    else $error("reinsert into full queue");

  a_nres_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= 5'(MAX_OUT))
    else $error("result buffer overrun");

endmodule

@@ hw/rtl/sorted_deadline_timer_queue_unit.sv @@
// Top level of the deadline-sorted timer queue.
// Usage:
//  The slave stream carries one request per transfer: tuser holds the op
//  (start one-shot, start periodic, cancel, tick of one millisecond), tdata
//  holds delay, tag and cancel identifier. The master stream returns one or
//  more results per request; tlast marks the final one, tuser holds the kind.
//  Every result of a request carries next_ms as it stands after the request.
//  Sequence:
//  A start or cancel passes through intake, then emission;
//  the result shows on the master side the cycle after it is emitted.
//  A tick runs the expiry loop: a check, then a pop per one-shot
//  expiry and a pop then sorted reinsert per periodic expiry, then emission
//  of each result; expiries leave through the slot shift register.
//  Up to 16 timers expire per tick.
//  Reset clears the clock, the slot count and identifiers; no clearing pass.
//  Stall: results sit in an output register; while the last one waits, the
//  next request is taken. A stall on the master side holds emission.
module sorted_deadline_timer_queue_unit
  import sdtq_pkg::*;
#(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // delay_ms[15:0], tag[31:16], cancel_id[35:32]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // timer_id[3:0], expired_tag[19:4], next_ms[37:20]
  output logic [2:0]  m_axis_tuser,  // kind[2:0]
  output logic        m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;
  logic [3:0]        out_id;
  logic [15:0]       out_tag;
  logic [NEXT_W-1:0] out_next;

  // sequence the request
  sdtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // hold the sorted slots and the result buffer
  sdtq_dp #(
    .SLOTS      (SLOTS),
    .DELAY_BITS (DELAY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (s_axis_tuser),
    .delay_i     (s_axis_tdata[15:0]),
    .tag_i       (s_axis_tdata[31:16]),
    .cancel_id_i (s_axis_tdata[35:32]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_id_o    (out_id),
    .out_tag_o   (out_tag),
    .out_next_o  (out_next),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_next, out_tag, out_id};

endmodule
